### design/crl_pkg.sv
// shared types and constants for the closed catmull-rom curve evaluator
`timescale 1ns / 1ps
`default_nettype none

package crl_pkg;

    // opcodes of an input transaction
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam int MAX_POINTS_DEF = 128;
    localparam int COORD_W        = 32;
    localparam int PT_W           = 3 * COORD_W;
    localparam int FRAC_W         = 16;
    localparam int CNT_W          = 8;
    localparam int IDX_W          = 7;
    localparam int CNT_RESET      = 4;
    localparam int WT_W           = 19;
    localparam int PROD_W         = COORD_W + WT_W;
    localparam int ACC_W          = PROD_W + 3;
    localparam int OQ_DEPTH       = 4;
    localparam int OQ_AW          = 2;
    localparam int OQ_CW          = 3;

    typedef logic signed [WT_W-1:0] t_weight;
    typedef t_weight [3:0] t_weight_set;

    // tag travelling with each point read
    typedef struct packed {
        logic       valid;
        logic [1:0] k;
    } t_tag;

endpackage

`default_nettype wire

### design/crl_seq.sv
// sequencer and control point memory: writes points, issues four reads per evaluation
`timescale 1ns / 1ps
`default_nettype none

module crl_seq #(
    parameter int MAX_POINTS = crl_pkg::MAX_POINTS_DEF,
    parameter int AW         = $clog2(MAX_POINTS),
    parameter int NW         = $clog2(MAX_POINTS + 1)
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_accept,
    input  wire                                i_opcode,
    input  wire [crl_pkg::IDX_W-1:0]           i_point_index,
    input  wire [crl_pkg::PT_W-1:0]            i_point,
    input  wire [crl_pkg::FRAC_W-1:0]          i_t_global,
    input  wire [NW-1:0]                       i_n,
    output logic                               o_hold,
    output logic [crl_pkg::PT_W-1:0]           o_rd,
    output crl_pkg::t_tag                      o_tag,
    output logic                               o_wstart,
    output logic [crl_pkg::FRAC_W-1:0]         o_t
);

    localparam int SW = crl_pkg::FRAC_W + NW;

    logic [crl_pkg::PT_W-1:0] r_mem [MAX_POINTS];

    logic                        r_busy;
    logic                        r_op;
    logic [1:0]                  r_k;
    logic [AW-1:0]               r_idx;
    logic [AW-1:0]               r_nm1;
    logic [crl_pkg::FRAC_W-1:0]  r_t;
    logic [AW-1:0]               r_waddr;
    logic [crl_pkg::PT_W-1:0]    r_wdata;
    logic                        r_wok;
    logic [crl_pkg::PT_W-1:0]    r_rd;
    crl_pkg::t_tag               r_tag;

    logic [SW-1:0] s;
    logic [NW-1:0] seg;
    logic [NW-1:0] nm1;
    logic [AW-1:0] i0;
    logic          last;
    logic          rd_en;
    logic          wr_en;

    // segment and first neighbour from the scaled parameter
    always_comb begin
        s   = SW'(i_t_global) * SW'(i_n);
        seg = s[SW-1:crl_pkg::FRAC_W];
        nm1 = i_n - 1'b1;
        i0  = (seg == '0) ? AW'(nm1) : AW'(seg - 1'b1);
    end

    assign last   = r_busy && ((r_op == crl_pkg::OP_WRITE) || (r_k == 2'd3));
    assign o_hold = r_busy && !last;
    assign rd_en  = r_busy && (r_op == crl_pkg::OP_EVAL);
    assign wr_en  = r_busy && (r_op == crl_pkg::OP_WRITE) && r_wok;

    // transaction context and read counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= crl_pkg::OP_WRITE;
            r_k    <= 2'd0;
        end else if (i_accept) begin
            r_busy <= 1'b1;
            r_op   <= i_opcode;
            r_k    <= 2'd0;
        end else if (last) begin
            r_busy <= 1'b0;
        end else if (r_busy) begin
            r_k <= r_k + 2'd1;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_idx   <= i0;
            r_nm1   <= AW'(nm1);
            r_t     <= s[crl_pkg::FRAC_W-1:0];
            r_waddr <= AW'(i_point_index);
            r_wdata <= i_point;
            r_wok   <= (32'(i_point_index) < MAX_POINTS);
        end else if (rd_en) begin
            r_idx <= (r_idx == r_nm1) ? '0 : r_idx + 1'b1;
        end
    end

    // single port point memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_waddr] <= r_wdata;
        end else if (rd_en) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // read tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag.valid <= rd_en;
            r_tag.k     <= r_k;
        end
    end

    assign o_rd     = r_rd;
    assign o_tag    = r_tag;
    assign o_wstart = rd_en && (r_k == 2'd0);
    assign o_t      = r_t;

endmodule

`default_nettype wire

### design/crl_weights.sv
// cubic basis weights from the local parameter over three stages
`timescale 1ns / 1ps
`default_nettype none

module crl_weights (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire [crl_pkg::FRAC_W-1:0]     i_t,
    output crl_pkg::t_weight_set          o_w
);

    logic                         r_v1;
    logic                         r_v2;
    logic [crl_pkg::FRAC_W-1:0]   r_t2;
    logic [crl_pkg::FRAC_W-1:0]   r_t3;
    crl_pkg::t_weight_set         r_w;

    logic [2*crl_pkg::FRAC_W-1:0] sq;
    logic [2*crl_pkg::FRAC_W-1:0] cu;
    logic signed [19:0]           e1, e2, e3;
    logic signed [19:0]           d0, d1, d2, d3;

    assign sq = i_t * i_t;
    assign cu = r_t2 * i_t;

    // doubled weights, exact
    always_comb begin
        e1 = {4'b0, i_t};
        e2 = {4'b0, r_t2};
        e3 = {4'b0, r_t3};
        d0 = (e2 <<< 1) - e3 - e1;
        d1 = (e3 <<< 1) + e3 - (e2 <<< 2) - e2 + 20'sd131072;
        d2 = (e2 <<< 2) + e1 - (e3 <<< 1) - e3;
        d3 = e3 - e2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
    end

    // halving is a floor, so drop the low bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_t2 <= sq[2*crl_pkg::FRAC_W-1:crl_pkg::FRAC_W];
        end
        if (r_v1) begin
            r_t3 <= cu[2*crl_pkg::FRAC_W-1:crl_pkg::FRAC_W];
        end
        if (r_v2) begin
            r_w[0] <= d0[19:1];
            r_w[1] <= d1[19:1];
            r_w[2] <= d2[19:1];
            r_w[3] <= d3[19:1];
        end
    end

    assign o_w = r_w;

endmodule

`default_nettype wire

### design/crl_mac.sv
// one coordinate: weight multiply, four term accumulate, floor and saturate
`timescale 1ns / 1ps
`default_nettype none

module crl_mac (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire signed [crl_pkg::COORD_W-1:0]   i_d,
    input  crl_pkg::t_tag                       i_tag,
    input  crl_pkg::t_weight_set                i_w,
    output logic                                o_done,
    output logic signed [crl_pkg::COORD_W-1:0]  o_res
);

    localparam int SH_W = crl_pkg::ACC_W - crl_pkg::FRAC_W;
    localparam logic signed [SH_W-1:0] MAXV = SH_W'(64'sd2147483647);
    localparam logic signed [SH_W-1:0] MINV = -SH_W'(64'sd2147483648);

    logic signed [crl_pkg::COORD_W-1:0] r_d2, r_d3;
    crl_pkg::t_tag                      r_tag2, r_tag3, r_tag4;
    logic signed [crl_pkg::PROD_W-1:0]  r_prod;
    logic signed [crl_pkg::ACC_W-1:0]   r_acc;
    logic                               r_done;

    logic signed [crl_pkg::PROD_W-1:0]  prod;
    logic signed [SH_W-1:0]             sh;

    assign prod = r_d3 * i_w[r_tag3.k];

    // tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag2 <= '0;
            r_tag3 <= '0;
            r_tag4 <= '0;
            r_done <= 1'b0;
        end else begin
            r_tag2 <= i_tag;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            r_done <= r_tag4.valid && (r_tag4.k == 2'd3);
        end
    end

    // data delay, product and accumulator
    always_ff @(posedge i_clk) begin
        r_d2   <= i_d;
        r_d3   <= r_d2;
        r_prod <= prod;
        if (r_tag4.valid) begin
            if (r_tag4.k == 2'd0) begin
                r_acc <= crl_pkg::ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + crl_pkg::ACC_W'(r_prod);
            end
        end
    end

    // floor by arithmetic shift, then clamp
    always_comb begin
        sh = SH_W'(r_acc >>> crl_pkg::FRAC_W);
        if (sh > MAXV) begin
            o_res = 32'sh7FFFFFFF;
        end else if (sh < MINV) begin
            o_res = 32'sh80000000;
        end else begin
            o_res = sh[crl_pkg::COORD_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

### design/catmull_rom_loop_eval.sv
// top level of the closed uniform catmull-rom curve evaluator
//
// Input channel (i_in_valid / o_in_stall) takes one transaction per cycle
// when not stalled. Opcode write stores x, y, z into slot point_index and
// gives no result; opcode evaluate blends four neighbouring points at the
// Q0.16 loop parameter t_global and gives one x, y, z result.
// Output channel (o_out_valid / i_out_stall) returns results in order.
// Occupancy: an evaluation holds the single port point memory for one read
// per neighbour; a write holds it for its single write. The next transaction
// is accepted in the last memory cycle of the current one.
// A four entry result queue absorbs output stalls; when four evaluations are
// outstanding the input is stalled until the receiver takes a result.
// point_count is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset (synchronous, active low) sets point_count to 4 and empties the
// pipeline and queue; point memory contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_loop_eval #(
    parameter int MAX_POINTS = crl_pkg::MAX_POINTS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire [crl_pkg::CNT_W-1:0]            i_cfg_wr_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire                                 i_opcode,
    input  wire [crl_pkg::IDX_W-1:0]            i_point_index,
    input  wire signed [crl_pkg::COORD_W-1:0]   i_x_in,
    input  wire signed [crl_pkg::COORD_W-1:0]   i_y_in,
    input  wire signed [crl_pkg::COORD_W-1:0]   i_z_in,
    input  wire [crl_pkg::FRAC_W-1:0]           i_t_global,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [crl_pkg::COORD_W-1:0]  o_x_out,
    output logic signed [crl_pkg::COORD_W-1:0]  o_y_out,
    output logic signed [crl_pkg::COORD_W-1:0]  o_z_out
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int CW = crl_pkg::COORD_W;

    logic [crl_pkg::CNT_W-1:0]  r_point_count;
    logic [crl_pkg::OQ_CW-1:0]  r_cnt;
    logic [crl_pkg::OQ_CW-1:0]  r_fill;
    logic [crl_pkg::OQ_AW-1:0]  r_wp, r_rp;
    logic [crl_pkg::PT_W-1:0]   r_q [crl_pkg::OQ_DEPTH];

    logic                       hold;
    logic                       in_acc;
    logic                       eval_acc;
    logic                       out_acc;
    logic [NW-1:0]              n;
    logic [crl_pkg::PT_W-1:0]   rd;
    crl_pkg::t_tag              tag;
    logic                       wstart;
    logic [crl_pkg::FRAC_W-1:0] t_loc;
    crl_pkg::t_weight_set       w;
    logic                       done_x, done_y, done_z;
    logic signed [CW-1:0]       res_x, res_y, res_z;

    // effective point count
    always_comb begin
        if (r_point_count == '0) begin
            n = NW'(1);
        end else if (32'(r_point_count) > MAX_POINTS) begin
            n = NW'(MAX_POINTS);
        end else begin
            n = NW'(r_point_count);
        end
    end

    assign o_in_stall = hold || (r_cnt == crl_pkg::OQ_CW'(crl_pkg::OQ_DEPTH));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign eval_acc   = in_acc && (i_opcode == crl_pkg::OP_EVAL);
    assign out_acc    = o_out_valid && !i_out_stall;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= crl_pkg::CNT_W'(crl_pkg::CNT_RESET);
        end else if (i_cfg_wr_en) begin
            r_point_count <= i_cfg_wr_data;
        end
    end

    crl_seq #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW),
        .NW         (NW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_acc),
        .i_opcode      (i_opcode),
        .i_point_index (i_point_index),
        .i_point       ({i_x_in, i_y_in, i_z_in}),
        .i_t_global    (i_t_global),
        .i_n           (n),
        .o_hold        (hold),
        .o_rd          (rd),
        .o_tag         (tag),
        .o_wstart      (wstart),
        .o_t           (t_loc)
    );

    crl_weights u_weights (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wstart),
        .i_t     (t_loc),
        .o_w     (w)
    );

    crl_mac u_mac_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (rd[3*CW-1:2*CW]),
        .i_tag (tag), .i_w (w), .o_done (done_x), .o_res (res_x)
    );

    crl_mac u_mac_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (rd[2*CW-1:CW]),
        .i_tag (tag), .i_w (w), .o_done (done_y), .o_res (res_y)
    );

    crl_mac u_mac_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_d (rd[CW-1:0]),
        .i_tag (tag), .i_w (w), .o_done (done_z), .o_res (res_z)
    );

    // outstanding evaluations and result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_fill <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
        end else begin
            r_cnt  <= r_cnt + crl_pkg::OQ_CW'(eval_acc) - crl_pkg::OQ_CW'(out_acc);
            r_fill <= r_fill + crl_pkg::OQ_CW'(done_x) - crl_pkg::OQ_CW'(out_acc);
            if (done_x) begin
                r_wp <= r_wp + 1'b1;
            end
            if (out_acc) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (done_x) begin
            r_q[r_wp] <= {res_x, res_y, res_z};
        end
    end

    assign o_out_valid = (r_fill != '0);
    assign o_x_out     = r_q[r_rp][3*CW-1:2*CW];
    assign o_y_out     = r_q[r_rp][2*CW-1:CW];
    assign o_z_out     = r_q[r_rp][CW-1:0];

    // checks
    a_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_x |-> (r_fill != crl_pkg::OQ_CW'(crl_pkg::OQ_DEPTH)))
        else $error("result queue overflow");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_cnt)
        else $error("queued results exceed outstanding evaluations");

    a_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_x == done_y) && (done_x == done_z))
        else $error("coordinate lanes out of step");

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the closed catmull-rom curve evaluator
`timescale 1ns / 1ps

module testbench;

    typedef struct {
        logic                        op;
        logic [crl_pkg::IDX_W-1:0]   slot;
        logic signed [31:0]          x;
        logic signed [31:0]          y;
        logic signed [31:0]          z;
        logic [15:0]                 tg;
    } t_txn;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_point;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [crl_pkg::CNT_W-1:0] cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = crl_pkg::OP_WRITE;
    logic [crl_pkg::IDX_W-1:0] slot = '0;
    logic signed [31:0] x_in = '0, y_in = '0, z_in = '0;
    logic [15:0] tg = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] x_out, y_out, z_out;

    t_txn   pending[$];
    t_point curve_pts[$];
    t_point point_table[crl_pkg::MAX_POINTS_DEF];
    int     loop_len = crl_pkg::CNT_RESET;
    int     errors = 0;
    bit     calm = 1'b0;     // no idling on either side
    bit     hold_go = 1'b0;  // starts the long receiver hold-off
    bit     hold_off = 1'b0; // receiver holding off

    catmull_rom_loop_eval dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_opcode(op), .i_point_index(slot),
        .i_x_in(x_in), .i_y_in(y_in), .i_z_in(z_in), .i_t_global(tg),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_x_out(x_out), .o_y_out(y_out), .o_z_out(z_out)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // one coordinate blended over four neighbours, floored and saturated
    function automatic logic signed [31:0] blend_coord(longint c[4], longint w[4]);
        longint acc;
        acc = 0;
        for (int k = 0; k < 4; k++) acc += c[k] * w[k];
        acc = acc >>> 16;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        return acc[31:0];
    endfunction

    // curve point at a loop parameter; updates the point table on writes
    task automatic apply_txn(t_txn t);
        longint n, s, seg, u, u2, u3, w[4], cx[4], cy[4], cz[4];
        longint i0;
        t_point p;
        t_point r;
        if (t.op == crl_pkg::OP_WRITE) begin
            point_table[t.slot] = '{t.x, t.y, t.z};
            return;
        end
        n = loop_len < 1 ? 1 : (loop_len > crl_pkg::MAX_POINTS_DEF ?
                                crl_pkg::MAX_POINTS_DEF : loop_len);
        s = longint'(t.tg) * n;
        seg = s >> 16;
        u = s & 16'hffff;
        u2 = (u * u) >> 16;
        u3 = (u2 * u) >> 16;
        w[0] = (-u3 + 2 * u2 - u) >>> 1;
        w[1] = (3 * u3 - 5 * u2 + 2 * 65536) >>> 1;
        w[2] = (-3 * u3 + 4 * u2 + u) >>> 1;
        w[3] = (u3 - u2) >>> 1;
        i0 = (seg + n - 1) % n;
        for (int k = 0; k < 4; k++) begin
            p = point_table[(i0 + k) % n];
            cx[k] = p.x; cy[k] = p.y; cz[k] = p.z;
        end
        r = '{blend_coord(cx, w), blend_coord(cy, w), blend_coord(cz, w)};
        curve_pts.insert(curve_pts.size(), r);
    endtask

    // driver: offers queued transactions, predicts on acceptance
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                apply_txn(pending.pop_front());
            end
            if (!(in_valid && in_stall)) begin
                if (pending.size() > 0 && (calm || $urandom_range(99) >= 32)) begin
                    in_valid <= 1'b1;
                    op <= pending[0].op;
                    slot <= pending[0].slot;
                    x_in <= pending[0].x;
                    y_in <= pending[0].y;
                    z_in <= pending[0].z;
                    tg <= pending[0].tg;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted in cycles
    initial begin
        wait (hold_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // monitor: checks results and drives the output stall
    always @(posedge clk) begin
        t_point e;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (curve_pts.size() == 0) begin
                    $error("result with nothing expected");
                    errors++;
                end else begin
                    e = curve_pts.pop_front();
                    if (x_out !== e.x) begin
                        $error("x_out expected %0d actual %0d", e.x, x_out); errors++;
                    end
                    if (y_out !== e.y) begin
                        $error("y_out expected %0d actual %0d", e.y, y_out); errors++;
                    end
                    if (z_out !== e.z) begin
                        $error("z_out expected %0d actual %0d", e.z, z_out); errors++;
                    end
                end
            end
            if (hold_off) begin
                out_stall <= 1'b1;
            end else begin
                out_stall <= !calm && ($urandom_range(99) < 32);
            end
        end
    end

    function automatic t_txn wr_txn(int idx, logic signed [31:0] x, y, z);
        t_txn t;
        t = '{crl_pkg::OP_WRITE, idx[crl_pkg::IDX_W-1:0], x, y, z, 16'($urandom)};
        return t;
    endfunction

    function automatic t_txn ev_txn(logic [15:0] g);
        t_txn t;
        t = '{crl_pkg::OP_EVAL, 7'($urandom), $urandom, $urandom, $urandom, g};
        return t;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $signed(32'($urandom_range(65536 * 8))) - 32'sd262144;
            default: return $urandom;
        endcase
    endfunction

    // appends a transaction to the pending queue
    task automatic queue_txn(t_txn t);
        pending.insert(pending.size(), t);
    endtask

    task automatic drain();
        while (pending.size() > 0 || curve_pts.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_loop_len(int n);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n[crl_pkg::CNT_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        loop_len = n;
    endtask

    // fills the table slots in use so that no unwritten point is read
    task automatic fill_slots(int n);
        for (int i = 0; i < n; i++)
            queue_txn(wr_txn(i, rand_coord(), rand_coord(), rand_coord()));
    endtask

    initial begin
        int counts[8] = '{4, 1, 128, 0, 200, 255, 2, 7};
        int n, used;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes of coordinates and parameter at reset count
        queue_txn(wr_txn(0, 32'sh7fffffff, 32'sh80000000, 0));
        queue_txn(wr_txn(1, 32'sh7fffffff, 32'sh80000000, -1));
        queue_txn(wr_txn(2, 32'sh80000000, 32'sh7fffffff, 65536));
        queue_txn(wr_txn(3, 32'sh80000000, 32'sh7fffffff, -65536));
        queue_txn(wr_txn(127, 32'sh55555555, 32'shaaaaaaaa, 32'sh12345678));
        queue_txn(ev_txn(16'h0000));
        queue_txn(ev_txn(16'hffff));
        queue_txn(ev_txn(16'h8000));
        queue_txn(ev_txn(16'h2000));
        queue_txn(ev_txn(16'h3fff));
        queue_txn(ev_txn(16'h5555));
        queue_txn(ev_txn(16'haaaa));
        drain();

        // long hold-off so the result queue fills and the input stalls
        hold_go = 1'b1;
        for (int i = 0; i < 12; i++) queue_txn(ev_txn(16'($urandom)));
        drain();

        // random phases over several loop lengths, extremes included
        foreach (counts[c]) begin
            n = counts[c];
            set_loop_len(n);
            used = n < 1 ? 1 : (n > crl_pkg::MAX_POINTS_DEF ? crl_pkg::MAX_POINTS_DEF : n);
            fill_slots(used);
            calm = (c == 2);
            for (int i = 0; i < 100; i++) begin
                if ($urandom_range(4) == 0)
                    queue_txn(wr_txn($urandom_range(127), rand_coord(),
                                     rand_coord(), rand_coord()));
                else
                    queue_txn(ev_txn(i % 20 == 0 ? 16'hffff : 16'($urandom)));
            end
            drain();
        end
        calm = 1'b0;

        if (errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #20ms;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

### filelist.f
design/crl_pkg.sv
design/crl_seq.sv
design/crl_weights.sv
design/crl_mac.sv
design/catmull_rom_loop_eval.sv
tb/testbench.sv
